// ===== rtl/lgf_pkg.sv =====
// Shared types and constants for the lcm / gcd / factorial unit.
`timescale 1ns / 1ps

package lgf_pkg;

    localparam int LGF_OPERAND_BITS = 16;   // default operand width
    localparam int OP_W             = 2;
    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 2;
    // factorial product (< 2^32) times index (< 16) needs 36 bits
    localparam int FACT_ACC_W       = 36;
    localparam int FACT_IDX_W       = 4;    // 13! is the first factorial past 32 bits
    localparam logic [FACT_IDX_W-1:0] FACT_FIRST_IDX = 4'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LCM  = 2'd0,
        OP_GCD  = 2'd1,
        OP_FACT = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    // flags of the shared adder; on subtract, carry set means a >= b
    typedef struct packed {
        logic carry;
        logic zero;
    } alu_flags_t;

endpackage

// ===== rtl/lcm_gcd_factorial_unit_core.sv =====
// Top level: iterative lcm, gcd and factorial unit around one shared adder.
//
//  channel | ports                                   | dir | notes
//  --------+-----------------------------------------+-----+------------------------------
//  request | s_valid s_ready s_op s_operand_a/b      | in  | one word per request
//  result  | m_valid m_ready m_value m_status        | out | one word per request
//
// One request at a time: s_ready is high only while idle, and the result word
// waits in its register until m_ready takes it. All work runs through one
// add/subtract unit. The gcd is binary Euclid, followed by shift-back steps
// that restore the common power of two; lcm then adds a restoring divide a / g
// and a shift-add multiply by b; factorial takes up to 12 multiplies, each
// after a loop test. Zero operands of lcm or gcd and unused op codes go
// straight to the result word. Reset is synchronous, active low, and drops
// any request in flight.
`timescale 1ns / 1ps

module lcm_gcd_factorial_unit_core #(
    parameter int OPERAND_BITS = lgf_pkg::LGF_OPERAND_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lgf_pkg::OP_W-1:0]     s_op,
    input  logic [OPERAND_BITS-1:0]      s_operand_a,
    input  logic [OPERAND_BITS-1:0]      s_operand_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lgf_pkg::VALUE_W-1:0]  m_value,
    output logic [lgf_pkg::STATUS_W-1:0] m_status
);
    import lgf_pkg::*;

    localparam int W     = OPERAND_BITS;
    // wide enough for a W x W product and for the factorial product
    localparam int ACC_W = (2 * W > FACT_ACC_W) ? 2 * W : FACT_ACC_W;
    localparam int K_W   = $clog2(W + 1);

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,    // waiting for a request word
        S_GCD  = 7'b0000010,    // binary gcd step
        S_FIX  = 7'b0000100,    // restore common power of two
        S_DIV  = 7'b0001000,    // restoring divide a / g
        S_MUL  = 7'b0010000,    // shift-add multiply
        S_FACT = 7'b0100000,    // factorial loop test
        S_DONE = 7'b1000000     // result word held for the sink
    } state_t;

    state_t                  state_reg,  state_next;
    op_t                     op_reg,     op_next;
    logic [W-1:0]            a_reg,      a_next;
    logic [W-1:0]            b_reg,      b_next;
    logic [W-1:0]            x_reg,      x_next;     // gcd operand, later g
    logic [W-1:0]            y_reg,      y_next;
    logic [K_W-1:0]          k_reg,      k_next;     // common factors of two
    logic [W-1:0]            rem_reg,    rem_next;
    logic [W-1:0]            q_reg,      q_next;     // dividend in, quotient out
    logic [K_W-1:0]          cnt_reg,    cnt_next;
    logic [ACC_W-1:0]        acc_reg,    acc_next;   // product accumulator
    logic [ACC_W-1:0]        mcand_reg,  mcand_next;
    logic [W-1:0]            mplier_reg, mplier_next;
    logic [FACT_IDX_W-1:0]   idx_reg,    idx_next;
    logic [VALUE_W-1:0]      value_reg,  value_next;
    status_t                 status_reg, status_next;

    // shared adder
    logic [ACC_W-1:0]        alu_a;
    logic [ACC_W-1:0]        alu_b;
    logic                    alu_sub;
    logic [ACC_W-1:0]        alu_res;
    alu_flags_t              alu_flags;

    logic [ACC_W-1:0]        x_wide;
    logic [W-1:0]            gcd_diff;
    logic                    acc_ovf;
    op_t                     s_op_t;

    assign s_op_t   = op_t'(s_op);
    assign x_wide   = ACC_W'(x_reg);
    assign gcd_diff = alu_res[W-1:0];
    assign acc_ovf  = (acc_reg[ACC_W-1:VALUE_W] != '0);

    lgf_alu #(
        .WIDTH (ACC_W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .flags (alu_flags)
    );

    // operand select for the shared adder
    always_comb begin
        case (state_reg)
            S_GCD: begin
                alu_a   = ACC_W'(x_reg);
                alu_b   = ACC_W'(y_reg);
                alu_sub = 1'b1;
            end
            S_DIV: begin
                // trial subtract of the divisor from the shifted remainder
                alu_a   = ACC_W'({rem_reg, q_reg[W-1]});
                alu_b   = ACC_W'(x_reg);
                alu_sub = 1'b1;
            end
            S_MUL: begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
            S_FACT: begin
                // carry clear means index > n: loop done
                alu_a   = ACC_W'(a_reg);
                alu_b   = ACC_W'(idx_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        k_next      = k_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        status_next = status_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next = s_op_t;
                    a_next  = s_operand_a;
                    b_next  = s_operand_b;
                    case (s_op_t)
                        OP_LCM, OP_GCD: begin
                            if ((s_operand_a == '0) || (s_operand_b == '0)) begin
                                value_next  = '0;
                                status_next = ST_ZERO;
                                state_next  = S_DONE;
                            end else begin
                                x_next     = s_operand_a;
                                y_next     = s_operand_b;
                                k_next     = '0;
                                state_next = S_GCD;
                            end
                        end
                        OP_FACT: begin
                            acc_next   = ACC_W'(1);
                            idx_next   = FACT_FIRST_IDX;
                            state_next = S_FACT;
                        end
                        default: begin
                            value_next  = '0;
                            status_next = ST_OK;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            S_GCD: begin
                if (alu_flags.zero) begin
                    state_next = S_FIX;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + K_W'(1);
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (!alu_flags.carry) begin
                    // both odd, x < y: swap so the larger sits in x
                    x_next = y_reg;
                    y_next = x_reg;
                end else begin
                    x_next = gcd_diff >> 1;
                end
            end

            S_FIX: begin
                if (k_reg == '0) begin
                    if (op_reg == OP_GCD) begin
                        value_next  = x_wide[VALUE_W-1:0];
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end else begin
                        rem_next   = '0;
                        q_next     = a_reg;
                        cnt_next   = K_W'(W);
                        state_next = S_DIV;
                    end
                end else begin
                    x_next = x_reg << 1;
                    k_next = k_reg - K_W'(1);
                end
            end

            S_DIV: begin
                if (cnt_reg == '0) begin
                    acc_next    = '0;
                    mcand_next  = ACC_W'(q_reg);
                    mplier_next = b_reg;
                    state_next  = S_MUL;
                end else begin
                    rem_next = alu_flags.carry ? alu_res[W-1:0]
                                               : {rem_reg[W-2:0], q_reg[W-1]};
                    q_next   = {q_reg[W-2:0], alu_flags.carry};
                    cnt_next = cnt_reg - K_W'(1);
                end
            end

            S_MUL: begin
                if (mplier_reg == '0) begin
                    if (acc_ovf) begin
                        value_next  = '1;
                        status_next = ST_OVF;
                        state_next  = S_DONE;
                    end else if (op_reg == OP_FACT) begin
                        idx_next   = idx_reg + FACT_IDX_W'(1);
                        state_next = S_FACT;
                    end else begin
                        value_next  = acc_reg[VALUE_W-1:0];
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                end else begin
                    if (mplier_reg[0]) begin
                        acc_next = alu_res;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end

            S_FACT: begin
                if (!alu_flags.carry) begin
                    value_next  = acc_reg[VALUE_W-1:0];
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end else begin
                    acc_next    = '0;
                    mcand_next  = acc_reg;
                    mplier_next = W'(idx_reg);
                    state_next  = S_MUL;
                end
            end

            S_DONE: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        k_reg      <= k_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = (state_reg == S_DONE);
    assign m_value  = value_reg;
    assign m_status = status_reg;

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request and result sides open at once");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after a request word");

    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_ZERO)) |-> (m_value == '0))
        else $error("zero-operand status with nonzero value");

    a_ovf_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_OVF)) |-> (m_value == '1))
        else $error("overflow status without saturated value");

endmodule

// ===== rtl/lgf_alu.sv =====
// Shared add / subtract unit with carry and zero flags.
`timescale 1ns / 1ps

module lgf_alu #(
    parameter int WIDTH = lgf_pkg::FACT_ACC_W
) (
    input  logic [WIDTH-1:0]     a,
    input  logic [WIDTH-1:0]     b,
    input  logic                 sub,
    output logic [WIDTH-1:0]     res,
    output lgf_pkg::alu_flags_t  flags
);
    import lgf_pkg::*;

    logic [WIDTH:0] sum;
    logic [WIDTH-1:0] b_op;

    assign b_op = b ^ {WIDTH{sub}};
    assign sum  = {1'b0, a} + {1'b0, b_op} + {{WIDTH{1'b0}}, sub};
    assign res  = sum[WIDTH-1:0];

    assign flags.carry = sum[WIDTH];
    assign flags.zero  = (sum[WIDTH-1:0] == '0);

endmodule
